>>> design/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared constants, codes and types of the grid bilinear interpolator.
// ----------------------------------------------------------------------------
package gbi_pkg;

   localparam int GBI_GRID_MAX = 64;

   // item codes carried in the mode field
   localparam logic [1:0] MODE_LOAD_X = 2'd0;
   localparam logic [1:0] MODE_LOAD_Y = 2'd1;
   localparam logic [1:0] MODE_LOAD_Z = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;

   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
   } div_rsp_type;

endpackage

>>> design/gbi_req_if.sv
// ----------------------------------------------------------------------------
// gbi_req_if
// Request channel: load words and query words.
// ----------------------------------------------------------------------------
interface gbi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [11:0]        load_index;
   logic signed [31:0] load_value;
   logic signed [31:0] query_x;
   logic signed [31:0] query_y;

   modport source (output valid, mode, load_index, load_value, query_x, query_y,
                   input ready);
   modport sink (input valid, mode, load_index, load_value, query_x, query_y,
                 output ready);
   modport monitor (input valid, ready, mode, load_index, load_value, query_x, query_y);
endinterface

>>> design/gbi_rsp_if.sv
// ----------------------------------------------------------------------------
// gbi_rsp_if
// Response channel: one result word per query.
// ----------------------------------------------------------------------------
interface gbi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] interp_value;
   logic               out_of_range;
   logic               degenerate;

   modport source (output valid, interp_value, out_of_range, degenerate, input ready);
   modport sink (input valid, interp_value, out_of_range, degenerate, output ready);
   modport monitor (input valid, ready, interp_value, out_of_range, degenerate);
endinterface

>>> design/gbi_div.sv
// ----------------------------------------------------------------------------
// gbi_div
// Bit-serial restoring divider for cell weights: quot = num * 2^31 / den,
// with num <= den, den > 0. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbi_div (
   input  logic                clock,
   input  logic                reset,
   input  gbi_pkg::div_req_type div_req,
   output gbi_pkg::div_rsp_type div_rsp
);
   import gbi_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] quot_ff, quot_in;
   logic [32:0] rem_sh;
   logic        ge;

   assign rem_sh = {rem_ff[31:0], 1'b0};
   assign ge     = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         den_in  = div_req.den;
         // integer part is one only when num equals den
         if (div_req.num >= div_req.den) begin
            rem_in  = {1'b0, div_req.num - div_req.den};
            quot_in = 32'd1;
         end else begin
            rem_in  = {1'b0, div_req.num};
            quot_in = 32'd0;
         end
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quot_in = {quot_ff[30:0], ge};
         cnt_in  = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

>>> design/grid_bilinear_interpolator.sv
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator
// Bilinear interpolation over a rectilinear grid of signed Q16.16 values.
// ----------------------------------------------------------------------------
// Load words (x knot, y knot, table value) are written when accepted. A query
// passes through two parallel binary searches over single-port knot memories,
// the shared bit-serial weight divider (once per axis), four table reads and
// the shared 32x33 multiplier that runs the six blend products. The block
// takes no word during a query; a finished result waits in the output register
// while the next word is accepted, and a second result waits in the last state
// until the first is taken. Table memory holds GRID_MAX*GRID_MAX entries
// indexed x_index*grid_size + y_index; csr_grid_size is taken as 2..GRID_MAX.
module grid_bilinear_interpolator #(
   parameter int GRID_MAX = gbi_pkg::GBI_GRID_MAX
) (
   input  logic       clock,
   input  logic       reset,
   gbi_req_if.sink    req_ch,
   gbi_rsp_if.source  rsp_ch,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [6:0] csr_grid_size
);
   import gbi_pkg::*;

   localparam int KW     = $clog2(GRID_MAX);
   localparam int NW     = $clog2(GRID_MAX + 1);
   localparam int TDEPTH = GRID_MAX * GRID_MAX;
   localparam int TW     = $clog2(TDEPTH);
   localparam logic [31:0] WONE = 32'h8000_0000;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RLO  = 5'd1;
   localparam logic [4:0] S_RHI  = 5'd2;
   localparam logic [4:0] S_RCHK = 5'd3;
   localparam logic [4:0] S_SA   = 5'd4;
   localparam logic [4:0] S_SB   = 5'd5;
   localparam logic [4:0] S_C0   = 5'd6;
   localparam logic [4:0] S_C1   = 5'd7;
   localparam logic [4:0] S_C2   = 5'd8;
   localparam logic [4:0] S_DXS  = 5'd9;
   localparam logic [4:0] S_DXW  = 5'd10;
   localparam logic [4:0] S_DYS  = 5'd11;
   localparam logic [4:0] S_DYW  = 5'd12;
   localparam logic [4:0] S_TB   = 5'd13;
   localparam logic [4:0] S_TR   = 5'd14;
   localparam logic [4:0] S_MUL  = 5'd15;
   localparam logic [4:0] S_FIN  = 5'd16;

   logic signed [31:0] x_mem [GRID_MAX];
   logic signed [31:0] y_mem [GRID_MAX];
   logic signed [31:0] t_mem [TDEPTH];

   logic [4:0]         state_ff, state_in;
   logic [6:0]         grid_ff;
   logic [NW-1:0]      n_ff, n_in;
   logic signed [31:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [31:0] xk0_ff, xk0_in, yk0_ff, yk0_in;
   logic signed [31:0] xa_ff, xa_in, ya_ff, ya_in;
   logic [NW-1:0]      xlo_ff, xlo_in, ylo_ff, ylo_in;
   logic [NW-1:0]      xlen_ff, xlen_in, ylen_ff, ylen_in;
   logic [KW-1:0]      xh_ff, xh_in, yh_ff, yh_in;
   logic [31:0]        tx_ff, tx_in, dx_ff, dx_in, ty_ff, ty_in, dy_ff, dy_in;
   logic [31:0]        wx_ff, wx_in, wy_ff, wy_in;
   logic [TW-1:0]      base_ff, base_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic signed [31:0] z_ff [4];
   logic signed [31:0] r0_ff, r0_in, r1_ff, r1_in;
   logic signed [64:0] prod_ff, acc_ff, acc_in;
   logic signed [31:0] val_ff, val_in;
   logic               oor_ff, oor_in, deg_ff, deg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_oor_ff, rsp_deg_ff;

   logic [KW-1:0]      x_raddr, y_raddr;
   logic [TW-1:0]      t_raddr;
   logic signed [31:0] x_rd_ff, y_rd_ff, t_rd_ff;
   logic               accept, load_out;
   logic [NW-1:0]      grid_clamp;
   logic [NW-1:0]      xhalf, yhalf;
   logic [NW-1:0]      nm1;
   logic signed [32:0] dxs, dys, txs, tys;
   logic signed [31:0] op_a;
   logic [31:0]        op_w;
   logic signed [64:0] sum;
   logic signed [33:0] rnd;
   logic [TW-1:0]      yl_t, yh_t, n_t;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   gbi_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign csr_ready    = 1'b1;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign load_out     = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      if ({25'd0, grid_ff} < 32'd2) begin
         grid_clamp = NW'(2);
      end else if ({25'd0, grid_ff} > 32'(GRID_MAX)) begin
         grid_clamp = NW'(GRID_MAX);
      end else begin
         grid_clamp = NW'(grid_ff);
      end
   end

   assign nm1   = n_ff - NW'(1);
   assign xhalf = xlen_ff >> 1;
   assign yhalf = ylen_ff >> 1;
   assign yl_t  = TW'(yh_ff - KW'(1));
   assign yh_t  = TW'(yh_ff);
   assign n_t   = TW'(n_ff);

   // knot and table read addresses, the read data is registered
   always_comb begin
      case (state_ff)
         S_RHI: begin
            x_raddr = KW'(nm1);
            y_raddr = KW'(nm1);
         end
         S_SA: begin
            x_raddr = KW'(xlo_ff + xhalf);
            y_raddr = KW'(ylo_ff + yhalf);
         end
         S_C0: begin
            x_raddr = xh_ff - KW'(1);
            y_raddr = yh_ff - KW'(1);
         end
         S_C1: begin
            x_raddr = xh_ff;
            y_raddr = yh_ff;
         end
         default: begin
            x_raddr = '0;
            y_raddr = '0;
         end
      endcase
      case (cnt_ff)
         3'd0:    t_raddr = base_ff + yl_t;
         3'd1:    t_raddr = base_ff + yh_t;
         3'd2:    t_raddr = base_ff + n_t + yl_t;
         default: t_raddr = base_ff + n_t + yh_t;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && req_ch.mode == MODE_LOAD_X &&
          {20'd0, req_ch.load_index} < 32'(GRID_MAX)) begin
         x_mem[KW'(req_ch.load_index)] <= req_ch.load_value;
      end
      if (accept && req_ch.mode == MODE_LOAD_Y &&
          {20'd0, req_ch.load_index} < 32'(GRID_MAX)) begin
         y_mem[KW'(req_ch.load_index)] <= req_ch.load_value;
      end
      x_rd_ff <= x_mem[x_raddr];
      y_rd_ff <= y_mem[y_raddr];
   end

   always_ff @(posedge clock) begin
      if (accept && req_ch.mode == MODE_LOAD_Z &&
          {20'd0, req_ch.load_index} < 32'(TDEPTH)) begin
         t_mem[TW'(req_ch.load_index)] <= req_ch.load_value;
      end
      t_rd_ff <= t_mem[t_raddr];
   end

   // blend operands: y pass for rows xl and xh, then x pass
   always_comb begin
      case (cnt_ff)
         3'd0:    op_a = z_ff[0];
         3'd1:    op_a = z_ff[1];
         3'd2:    op_a = z_ff[2];
         3'd3:    op_a = z_ff[3];
         3'd4:    op_a = r0_ff;
         default: op_a = r1_ff;
      endcase
      if (cnt_ff[0]) begin
         op_w = (cnt_ff < 3'd4) ? wy_ff : wx_ff;
      end else begin
         op_w = WONE - ((cnt_ff < 3'd4) ? wy_ff : wx_ff);
      end
   end

   assign sum = acc_ff + prod_ff;
   assign rnd = 34'((sum + 65'sd1073741824) >>> 31);

   assign dxs = 33'(x_rd_ff) - 33'(xa_ff);
   assign dys = 33'(y_rd_ff) - 33'(ya_ff);
   assign txs = 33'(qx_ff) - 33'(xa_ff);
   assign tys = 33'(qy_ff) - 33'(ya_ff);

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      xk0_in   = xk0_ff;
      yk0_in   = yk0_ff;
      xa_in    = xa_ff;
      ya_in    = ya_ff;
      xlo_in   = xlo_ff;
      ylo_in   = ylo_ff;
      xlen_in  = xlen_ff;
      ylen_in  = ylen_ff;
      xh_in    = xh_ff;
      yh_in    = yh_ff;
      tx_in    = tx_ff;
      dx_in    = dx_ff;
      ty_in    = ty_ff;
      dy_in    = dy_ff;
      wx_in    = wx_ff;
      wy_in    = wy_ff;
      base_in  = base_ff;
      cnt_in   = cnt_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      acc_in   = acc_ff;
      val_in   = val_ff;
      oor_in   = oor_ff;
      deg_in   = deg_ff;
      div_req.start = 1'b0;
      div_req.num   = tx_ff;
      div_req.den   = dx_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_ch.mode == MODE_QUERY) begin
               n_in     = grid_clamp;
               qx_in    = req_ch.query_x;
               qy_in    = req_ch.query_y;
               val_in   = '0;
               oor_in   = 1'b0;
               deg_in   = 1'b0;
               state_in = S_RLO;
            end
         end
         S_RLO: state_in = S_RHI;
         S_RHI: begin
            xk0_in   = x_rd_ff;
            yk0_in   = y_rd_ff;
            state_in = S_RCHK;
         end
         S_RCHK: begin
            if (qx_ff < xk0_ff || qx_ff > x_rd_ff || qy_ff < yk0_ff || qy_ff > y_rd_ff) begin
               oor_in   = 1'b1;
               state_in = S_FIN;
            end else begin
               xlo_in   = '0;
               ylo_in   = '0;
               xlen_in  = n_ff;
               ylen_in  = n_ff;
               state_in = S_SA;
            end
         end
         S_SA: begin
            if (xlen_ff == '0 && ylen_ff == '0) begin
               // clamp upper cell index into 1..n-1
               if (xlo_ff == '0) begin
                  xh_in = KW'(1);
               end else if (xlo_ff > nm1) begin
                  xh_in = KW'(nm1);
               end else begin
                  xh_in = KW'(xlo_ff);
               end
               if (ylo_ff == '0) begin
                  yh_in = KW'(1);
               end else if (ylo_ff > nm1) begin
                  yh_in = KW'(nm1);
               end else begin
                  yh_in = KW'(ylo_ff);
               end
               state_in = S_C0;
            end else begin
               state_in = S_SB;
            end
         end
         S_SB: begin
            if (xlen_ff != '0) begin
               if (x_rd_ff < qx_ff) begin
                  xlo_in  = xlo_ff + xhalf + NW'(1);
                  xlen_in = xlen_ff - xhalf - NW'(1);
               end else begin
                  xlen_in = xhalf;
               end
            end
            if (ylen_ff != '0) begin
               if (y_rd_ff < qy_ff) begin
                  ylo_in  = ylo_ff + yhalf + NW'(1);
                  ylen_in = ylen_ff - yhalf - NW'(1);
               end else begin
                  ylen_in = yhalf;
               end
            end
            state_in = S_SA;
         end
         S_C0: state_in = S_C1;
         S_C1: begin
            xa_in    = x_rd_ff;
            ya_in    = y_rd_ff;
            state_in = S_C2;
         end
         S_C2: begin
            if (x_rd_ff <= xa_ff || y_rd_ff <= ya_ff) begin
               deg_in   = 1'b1;
               state_in = S_FIN;
            end else begin
               dx_in = 32'(dxs);
               dy_in = 32'(dys);
               // clamp offset into the cell
               if (txs < 33'sd0) begin
                  tx_in = '0;
               end else if (txs > dxs) begin
                  tx_in = 32'(dxs);
               end else begin
                  tx_in = 32'(txs);
               end
               if (tys < 33'sd0) begin
                  ty_in = '0;
               end else if (tys > dys) begin
                  ty_in = 32'(dys);
               end else begin
                  ty_in = 32'(tys);
               end
               state_in = S_DXS;
            end
         end
         S_DXS: begin
            div_req.start = 1'b1;
            state_in      = S_DXW;
         end
         S_DXW: begin
            if (div_rsp.done) begin
               wx_in    = div_rsp.quot;
               state_in = S_DYS;
            end
         end
         S_DYS: begin
            div_req.start = 1'b1;
            div_req.num   = ty_ff;
            div_req.den   = dy_ff;
            state_in      = S_DYW;
         end
         S_DYW: begin
            if (div_rsp.done) begin
               wy_in    = div_rsp.quot;
               state_in = S_TB;
            end
         end
         S_TB: begin
            base_in  = TW'(TW'(xh_ff - KW'(1)) * TW'(n_ff));
            cnt_in   = '0;
            state_in = S_TR;
         end
         S_TR: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff != 3'd0) begin
               if (!cnt_ff[0]) begin
                  case (cnt_ff)
                     3'd2:    r0_in = 32'(rnd);
                     3'd4:    r1_in = 32'(rnd);
                     default: begin
                        if (rnd > 34'sh0_7FFF_FFFF) begin
                           val_in = 32'sh7FFF_FFFF;
                        end else if (rnd < -34'sh0_8000_0000) begin
                           val_in = 32'sh8000_0000;
                        end else begin
                           val_in = 32'(rnd);
                        end
                     end
                  endcase
               end else begin
                  acc_in = prod_ff;
               end
            end
            if (cnt_ff == 3'd6) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         grid_ff      <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            grid_ff <= csr_grid_size;
         end
      end
      n_ff    <= n_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      xk0_ff  <= xk0_in;
      yk0_ff  <= yk0_in;
      xa_ff   <= xa_in;
      ya_ff   <= ya_in;
      xlo_ff  <= xlo_in;
      ylo_ff  <= ylo_in;
      xlen_ff <= xlen_in;
      ylen_ff <= ylen_in;
      xh_ff   <= xh_in;
      yh_ff   <= yh_in;
      tx_ff   <= tx_in;
      dx_ff   <= dx_in;
      ty_ff   <= ty_in;
      dy_ff   <= dy_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
      base_ff <= base_in;
      cnt_ff  <= cnt_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      acc_ff  <= acc_in;
      val_ff  <= val_in;
      oor_ff  <= oor_in;
      deg_ff  <= deg_in;
      if (state_ff == S_TR && cnt_ff != 3'd0) begin
         z_ff[2'(cnt_ff - 3'd1)] <= t_rd_ff;
      end
      if (state_ff == S_MUL && cnt_ff < 3'd6) begin
         prod_ff <= 65'(op_a) * $signed({33'd0, op_w});
      end
      if (load_out) begin
         rsp_value_ff <= val_ff;
         rsp_oor_ff   <= oor_ff;
         rsp_deg_ff   <= deg_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.interp_value = rsp_value_ff;
   assign rsp_ch.out_of_range = rsp_oor_ff;
   assign rsp_ch.degenerate   = rsp_deg_ff;

endmodule

>>> design/gbi_checker.sv
// ----------------------------------------------------------------------------
// gbi_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module gbi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_interp_value,
   input logic        rsp_out_of_range,
   input logic        rsp_degenerate
);
   import gbi_pkg::*;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_interp_value))
      else $error("result word changed while stalled");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_out_of_range && rsp_degenerate))
      else $error("both flags set");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_of_range || rsp_degenerate)
         |-> rsp_interp_value == 32'd0)
      else $error("flagged result not zero");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_QUERY |=> !req_ready)
      else $error("word accepted during query");

endmodule

bind grid_bilinear_interpolator gbi_checker u_gbi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_mode         (req_ch.mode),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_interp_value (rsp_ch.interp_value),
   .rsp_out_of_range (rsp_ch.out_of_range),
   .rsp_degenerate   (rsp_ch.degenerate)
);

>>> test/grid_bilinear_interpolator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_bilinear_interpolator_tb
// Loads knot vectors and value tables at several grid sizes, sends directed
// and random queries with random stalls on both channels, and compares every
// result word with a behavioral predictor of the interpolator.
// ----------------------------------------------------------------------------
module grid_bilinear_interpolator_tb;
   import gbi_pkg::*;

   localparam int GRID_MAX_DEF = GBI_GRID_MAX;

   typedef struct packed {
      logic [1:0]         mode;
      logic [11:0]        load_index;
      logic signed [31:0] load_value;
      logic signed [31:0] query_x;
      logic signed [31:0] query_y;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] interp_value;
      logic               out_of_range;
      logic               degenerate;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [6:0] csr_grid_size = 7'd64;

   gbi_req_if req_ch ();
   gbi_rsp_if rsp_ch ();

   grid_bilinear_interpolator DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_grid_size(csr_grid_size)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   req_word_type pending_words[$];
   rsp_word_type expected_results[$];
   int  error_count = 0;
   bit  quiet_mode = 1'b0;
   bit  sink_hold = 1'b0;
   bit  req_taken = 1'b0;
   int  sender_gap = 0;
   int  sink_gap = 0;

   // predictor state
   logic signed [31:0] px_knots[GRID_MAX_DEF];
   logic signed [31:0] py_knots[GRID_MAX_DEF];
   logic signed [31:0] pz_table[GRID_MAX_DEF * GRID_MAX_DEF];
   int unsigned        p_size = 64;

   function automatic int unsigned find_upper(input bit is_x, input int unsigned n,
                                              input longint q);
      int unsigned lo, len, half;
      longint k;
      lo = 0;
      len = n;
      while (len > 0) begin
         half = len / 2;
         k = is_x ? px_knots[lo + half] : py_knots[lo + half];
         if (k < q) begin
            lo += half + 1;
            len -= half + 1;
         end else begin
            len = half;
         end
      end
      if (lo < 1) lo = 1;
      if (lo > n - 1) lo = n - 1;
      return lo;
   endfunction

   function automatic longint cell_weight(input longint q, input longint a, input longint b);
      longint d, t;
      d = b - a;
      t = q - a;
      if (t < 0) t = 0;
      if (t > d) t = d;
      return (t <<< 31) / d;
   endfunction

   // round half up of p*(1-w) + q*w, weight scale 2^31
   function automatic longint mix(input longint p, input longint q, input longint w);
      logic signed [127:0] v;
      v = 128'(p) * (128'sd1 <<< 31) - 128'(p) * w + 128'(q) * w + (128'sd1 <<< 30);
      return longint'(v >>> 31);
   endfunction

   function automatic void predict_word(input req_word_type w);
      int unsigned n, xh, yh, xl, yl;
      longint qx, qy, wx, wy, r0, r1, res;
      rsp_word_type r;
      case (w.mode)
         MODE_LOAD_X: begin
            if (w.load_index < GRID_MAX_DEF) px_knots[w.load_index] = w.load_value;
         end
         MODE_LOAD_Y: begin
            if (w.load_index < GRID_MAX_DEF) py_knots[w.load_index] = w.load_value;
         end
         MODE_LOAD_Z: begin
            if (w.load_index < GRID_MAX_DEF * GRID_MAX_DEF)
               pz_table[w.load_index] = w.load_value;
         end
         default: begin
            n = p_size;
            if (n < 2) n = 2;
            if (n > GRID_MAX_DEF) n = GRID_MAX_DEF;
            qx = w.query_x;
            qy = w.query_y;
            r = '0;
            if (qx < px_knots[0] || qx > px_knots[n - 1] ||
                qy < py_knots[0] || qy > py_knots[n - 1]) begin
               r.out_of_range = 1'b1;
            end else begin
               xh = find_upper(1'b1, n, qx);
               yh = find_upper(1'b0, n, qy);
               xl = xh - 1;
               yl = yh - 1;
               if (px_knots[xh] <= px_knots[xl] || py_knots[yh] <= py_knots[yl]) begin
                  r.degenerate = 1'b1;
               end else begin
                  wx = cell_weight(qx, px_knots[xl], px_knots[xh]);
                  wy = cell_weight(qy, py_knots[yl], py_knots[yh]);
                  r0 = mix(pz_table[xl * n + yl], pz_table[xl * n + yh], wy);
                  r1 = mix(pz_table[xh * n + yl], pz_table[xh * n + yh], wy);
                  res = mix(r0, r1, wx);
                  if (res > 64'sd2147483647) res = 64'sd2147483647;
                  if (res < -64'sd2147483648) res = -64'sd2147483648;
                  r.interp_value = res[31:0];
               end
            end
            expected_results.push_back(r);
         end
      endcase
   endfunction

   // driver
   initial begin
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_LOAD_X;
      req_ch.load_index = '0;
      req_ch.load_value = '0;
      req_ch.query_x = '0;
      req_ch.query_y = '0;
      rsp_ch.ready = 1'b0;
   end

   // take accepted request words at the edge that accepts them
   always @(posedge clock) begin
      req_taken = !reset && req_ch.valid && req_ch.ready;
      if (req_taken) begin
         predict_word(pending_words.pop_front());
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (sender_gap > 0) begin
            sender_gap <= sender_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            if (!quiet_mode && (req_taken || !req_ch.valid)
                && $urandom_range(0, 5) == 0) begin
               sender_gap <= $urandom_range(0, 2);
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid <= 1'b1;
               {req_ch.mode, req_ch.load_index, req_ch.load_value, req_ch.query_x,
                req_ch.query_y} <= pending_words[0];
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
         if (sink_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            sink_gap <= $urandom_range(0, 2);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result word interp_value=%0d", rsp_ch.interp_value);
            error_count++;
         end else begin
            exp_w = expected_results.pop_front();
            if (rsp_ch.interp_value !== exp_w.interp_value) begin
               $error("interp_value expected %0d actual %0d",
                      exp_w.interp_value, rsp_ch.interp_value);
               error_count++;
            end
            if (rsp_ch.out_of_range !== exp_w.out_of_range) begin
               $error("out_of_range expected %0b actual %0b",
                      exp_w.out_of_range, rsp_ch.out_of_range);
               error_count++;
            end
            if (rsp_ch.degenerate !== exp_w.degenerate) begin
               $error("degenerate expected %0b actual %0b",
                      exp_w.degenerate, rsp_ch.degenerate);
               error_count++;
            end
         end
      end
   end

   function automatic req_word_type make_load(input logic [1:0] m, input int idx,
                                              input logic [31:0] v);
      req_word_type w;
      w = '0;
      w.mode = m;
      w.load_index = idx[11:0];
      w.load_value = v;
      w.query_x = $urandom();
      w.query_y = $urandom();
      return w;
   endfunction

   function automatic req_word_type make_query(input logic [31:0] qx, input logic [31:0] qy);
      req_word_type w;
      w.mode = MODE_QUERY;
      w.load_index = 12'($urandom());
      w.load_value = $urandom();
      w.query_x = qx;
      w.query_y = qy;
      return w;
   endfunction

   task automatic drain();
      while (pending_words.size() > 0 || req_ch.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_size(input logic [6:0] s);
      @(negedge clock);
      csr_grid_size <= s;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      p_size = s;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   int unsigned grid_n;
   logic signed [31:0] xk[64], yk[64];

   // load full grid: sorted knots with random steps (some zero-width), random table
   task automatic load_grid(input int unsigned n, input bit wide);
      longint acc;
      int unsigned step;
      acc = wide ? -64'sd2147483648 : $signed($urandom_range(0, 2000)) - 1000;
      for (int i = 0; i < n; i++) begin
         step = wide ? 32'hFFFF_FFFF / n : $urandom_range(0, 9) == 0 ? 0 :
                $urandom_range(1, 300000);
         if (i > 0) acc += step;
         xk[i] = acc[31:0];
         pending_words.push_back(make_load(MODE_LOAD_X, i, xk[i]));
      end
      acc = wide ? -64'sd2147483648 : -$signed($urandom_range(0, 200000));
      for (int i = 0; i < n; i++) begin
         step = wide ? 32'hFFFF_FFFF / n : $urandom_range(0, 9) == 0 ? 0 :
                $urandom_range(1, 300000);
         if (i > 0) acc += step;
         yk[i] = acc[31:0];
         pending_words.push_back(make_load(MODE_LOAD_Y, i, yk[i]));
      end
      for (int i = 0; i < n * n; i++) begin
         pending_words.push_back(make_load(MODE_LOAD_Z, i,
            $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                      : $urandom()));
      end
   endtask

   function automatic logic [31:0] pick_coord(input bit is_x, input int unsigned n);
      int unsigned i;
      longint lo, hi;
      lo = is_x ? xk[0] : yk[0];
      hi = is_x ? xk[n - 1] : yk[n - 1];
      i = $urandom_range(0, 9);
      if (i == 0) return $urandom();
      if (i == 1) return is_x ? xk[$urandom_range(0, n - 1)] : yk[$urandom_range(0, n - 1)];
      if (i == 2) return 32'(lo - 1);
      if (i == 3) return 32'(hi + 1);
      return 32'(lo + longint'($urandom()) % (hi - lo + 1));
   endfunction

   initial begin
      int unsigned sizes[5] = '{8, 2, 5, 3, 12};
      int queries;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: tiny grid at size 2
      write_size(7'd2);
      xk[0] = 32'sh0000_0000; xk[1] = 32'sh0001_0000;
      yk[0] = 32'sh0000_0000; yk[1] = 32'sh0002_0000;
      pending_words.push_back(make_load(MODE_LOAD_X, 0, xk[0]));
      pending_words.push_back(make_load(MODE_LOAD_X, 1, xk[1]));
      pending_words.push_back(make_load(MODE_LOAD_Y, 0, yk[0]));
      pending_words.push_back(make_load(MODE_LOAD_Y, 1, yk[1]));
      pending_words.push_back(make_load(MODE_LOAD_Z, 0, 32'h7FFF_FFFF));
      pending_words.push_back(make_load(MODE_LOAD_Z, 1, 32'h7FFF_FFFF));
      pending_words.push_back(make_load(MODE_LOAD_Z, 2, 32'h8000_0000));
      pending_words.push_back(make_load(MODE_LOAD_Z, 3, 32'h0001_0000));
      // index too large: dropped
      pending_words.push_back(make_load(MODE_LOAD_X, 4095, 32'hFFFF_FFFF));
      pending_words.push_back(make_load(MODE_LOAD_Y, 64, 32'hFFFF_FFFF));
      pending_words.push_back(make_query(32'h0, 32'h0));              // lowest knot
      pending_words.push_back(make_query(32'h0001_0000, 32'h0002_0000)); // top corner
      pending_words.push_back(make_query(32'h0000_8000, 32'h0001_0000)); // middle
      pending_words.push_back(make_query(32'h0000_7FFF, 32'h0000_0001));
      pending_words.push_back(make_query(32'h8000_0000, 32'h0));       // out low
      pending_words.push_back(make_query(32'h0, 32'h7FFF_FFFF));       // out high
      pending_words.push_back(make_load(MODE_LOAD_X, 1, 32'h0));        // zero width
      pending_words.push_back(make_query(32'h0, 32'h0001_0000));
      drain();
      write_size(7'd0); // acts as two
      pending_words.push_back(make_query(32'h0, 32'h0));
      drain();

      // size above the maximum acts as 64: flat x knots make every cell degenerate
      write_size(7'd127);
      for (int i = 0; i < 64; i++) begin
         pending_words.push_back(make_load(MODE_LOAD_X, i, 32'h0));
         pending_words.push_back(make_load(MODE_LOAD_Y, i, 32'(i * 1000)));
      end
      for (int i = 0; i < 10; i++)
         pending_words.push_back(make_query(32'h0, 32'($urandom_range(0, 63000))));
      pending_words.push_back(make_query(32'h0, 32'd63001)); // above top knot
      drain();

      foreach (sizes[s]) begin
         write_size(sizes[s][6:0]);
         grid_n = sizes[s] < 2 ? 2 : sizes[s] > 64 ? 64 : sizes[s];
         load_grid(grid_n, s == 0);
         queries = 110;
         if (s == 4) quiet_mode = 1'b1;
         for (int q = 0; q < queries; q++) begin
            if ($urandom_range(0, 19) == 0)
               pending_words.push_back(make_load(
                  2'($urandom_range(MODE_LOAD_X, MODE_LOAD_Z)), $urandom_range(64, 4095),
                  $urandom()));
            pending_words.push_back(make_query(pick_coord(1'b1, grid_n),
                                               pick_coord(1'b0, grid_n)));
         end
         if (s == 1) begin
            // long receiver hold while words keep coming
            sink_hold = 1'b1;
            repeat (600) @(posedge clock);
            sink_hold = 1'b0;
         end
         drain();
      end
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
